### hdl/rtt_pkg.sv
// Package for the retransmit timeout table: item types, codes, register map and helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rtt_pkg;

   localparam int SEQ_W     = 32;
   localparam int TIME_W    = 32;
   localparam int TOTAL_W   = 32;
   localparam int RETRY_W   = 8;
   localparam int KIND_W    = 3;
   localparam int REQ_W     = 3;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int MAX_OUT             = 16;
   localparam int FOUND_W             = $clog2(MAX_OUT + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRIES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT   = 2'd2;

   localparam logic [TIME_W-1:0]  RETRY_TIMEOUT_RESET = 32'd100;
   localparam logic [RETRY_W-1:0] MAX_RETRIES_RESET   = 8'd3;
   localparam logic [TIME_W-1:0]  ACK_TIMEOUT_RESET   = 32'd500;

   localparam logic [REQ_W-1:0] REQ_RECORD     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ACK        = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TICK       = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RETRANSMIT = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LOSS       = 3'd4;

   localparam logic [KIND_W-1:0] KIND_DONE        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACK_MISS    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RETRANSMIT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOTHING_DUE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOSS_DONE   = 3'd4;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [SEQ_W-1:0] seq_num;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SEQ_W-1:0]   out_seq;
      logic [RETRY_W-1:0] retries_used;
      logic [TOTAL_W-1:0] acked_total;
      logic [TOTAL_W-1:0] resent_total;
      logic [TOTAL_W-1:0] lost_total;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [TIME_W-1:0]  retry_timeout;
      logic [RETRY_W-1:0] max_retries;
      logic [TIME_W-1:0]  ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic               acked;
      logic [TIME_W-1:0]  stamp;
      logic [RETRY_W-1:0] retries;
   } slot_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MOD,
      ST_ACK_CHECK,
      ST_SCAN,
      ST_FINISH
   } seq_state_type;

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
   endfunction

endpackage

### hdl/rtt_csr.sv
// Configuration registers of the retransmit timeout table behind an APB-style port.
// Depends on rtt_pkg for the register map, reset values and the cfg_type struct.
`timescale 1ns / 1ps

module rtt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rtt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rtt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rtt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output rtt_pkg::cfg_type                 cfg
);
   import rtt_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  wr_en;
   logic [CSR_IDX_W-1:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            CSR_RETRY_TIMEOUT: cfg_in.retry_timeout = pwdata[TIME_W-1:0];
            CSR_MAX_RETRIES:   cfg_in.max_retries   = pwdata[RETRY_W-1:0];
            CSR_ACK_TIMEOUT:   cfg_in.ack_timeout   = pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_RETRY_TIMEOUT: prdata = cfg_ff.retry_timeout;
         CSR_MAX_RETRIES:   prdata = {{(CSR_DATA_W-RETRY_W){1'b0}}, cfg_ff.max_retries};
         CSR_ACK_TIMEOUT:   prdata = cfg_ff.ack_timeout;
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_timeout <= RETRY_TIMEOUT_RESET;
         cfg_ff.max_retries   <= MAX_RETRIES_RESET;
         cfg_ff.ack_timeout   <= ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/rtt_index_mod.sv
// Remainder unit: sequence number mod table depth by reciprocal multiply, then subtract.
// Depends on rtt_pkg for widths.
`timescale 1ns / 1ps

module rtt_index_mod #(
   parameter int TABLE_DEPTH = rtt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rtt_pkg::SEQ_W-1:0]        dividend,
   output logic                             done,
   output logic [$clog2(TABLE_DEPTH)-1:0]   index
);
   import rtt_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int RECIP_W = SEQ_W + 1;
   localparam int PROD_W  = SEQ_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << (SEQ_W + IDX_W)) + longint'(TABLE_DEPTH) - longint'(1))
               / longint'(TABLE_DEPTH));
   localparam logic [IDX_W-1:0]   DEPTH_LO = IDX_W'(TABLE_DEPTH);

   logic [PROD_W-1:0] prod;
   logic [IDX_W-1:0]  quot_lo_ff, quot_lo_in;
   logic [IDX_W-1:0]  div_lo_ff, div_lo_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   assign done  = done_ff;
   assign index = rem_ff;
   assign prod  = PROD_W'(dividend) * PROD_W'(RECIP);

   // quotient low bits are enough: the remainder is below 2^IDX_W
   always_comb begin
      quot_lo_in = quot_lo_ff;
      div_lo_in  = div_lo_ff;
      rem_in     = rem_ff;
      run_in     = 1'b0;
      done_in    = 1'b0;
      if (start) begin
         quot_lo_in = prod[SEQ_W+IDX_W +: IDX_W];
         div_lo_in  = dividend[IDX_W-1:0];
         run_in     = 1'b1;
      end else if (run_ff) begin
         rem_in  = div_lo_ff - quot_lo_ff * DEPTH_LO;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quot_lo_ff <= quot_lo_in;
      div_lo_ff  <= div_lo_in;
      rem_ff     <= rem_in;
   end

endmodule

### hdl/rtt_slot_ram.sv
// Slot store of the retransmit timeout table: one write port, one registered read port.
// Depends on rtt_pkg for the slot entry layout.
`timescale 1ns / 1ps

module rtt_slot_ram #(
   parameter int TABLE_DEPTH = rtt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
   input  rtt_pkg::slot_entry_type          wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   output rtt_pkg::slot_entry_type          rd_data
);
   import rtt_pkg::*;

   slot_entry_type mem_ff [TABLE_DEPTH];
   slot_entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

### hdl/rtt_age_unit.sv
// Shared age check: (time_now - stamp) mod 2^32 compared strictly above a timeout.
// Depends on rtt_pkg for the time width.
`timescale 1ns / 1ps

module rtt_age_unit (
   input  logic [rtt_pkg::TIME_W-1:0] time_now,
   input  logic [rtt_pkg::TIME_W-1:0] stamp,
   input  logic [rtt_pkg::TIME_W-1:0] threshold,
   output logic                       over
);
   import rtt_pkg::*;

   logic [TIME_W-1:0] age;

   assign age  = time_now - stamp;
   assign over = age > threshold;

endmodule

### hdl/retransmit_timeout_table.sv
// Top level of the retransmit timeout table: sequencer, slot valid bits, time and totals.
// Depends on rtt_pkg, rtt_csr, rtt_index_mod, rtt_slot_ram and rtt_age_unit.
//
//   channel   handshake                           payload
//   request   start / busy                        req_data (req_item_type)
//   result    rsp_strobe, one cycle, no stall     rsp_data (rsp_item_type)
//   config    psel penable pwrite / pready        paddr, pwdata, prdata
//
// Busy stays high while a request is handled: decode alone on tick and unknown requests;
// decode and the remainder unit (reciprocal multiply, then subtract) on record; both and a
// slot check on ack. Scans hold busy through decode, a scan of one slot a cycle through the
// slot store read port and the shared age unit, and a finish state. Each result is registered
// before it strobes, the last in the first cycle with busy low. The receiver cannot stall.
// Synchronous reset clears valid bits, time, totals and control; slot data is not cleared.
`timescale 1ns / 1ps

module retransmit_timeout_table #(
   parameter int TABLE_DEPTH = rtt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  rtt_pkg::req_item_type            req_data,
   output logic                             rsp_strobe,
   output rtt_pkg::rsp_item_type            rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rtt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rtt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rtt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import rtt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0]   DEPTH_CNT   = CNT_W'(TABLE_DEPTH);
   localparam logic [FOUND_W-1:0] MAX_OUT_CNT = FOUND_W'(MAX_OUT);

   cfg_type                cfg;
   seq_state_type          state_ff, state_in;
   req_item_type           req_ff, req_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [TOTAL_W-1:0]     acked_ff, acked_in;
   logic [TOTAL_W-1:0]     resent_ff, resent_in;
   logic [TOTAL_W-1:0]     lost_ff, lost_in;
   logic [IDX_W-1:0]       slot_idx_ff, slot_idx_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   eval_valid_ff, eval_valid_in;
   logic [IDX_W-1:0]       eval_idx_ff, eval_idx_in;
   logic [FOUND_W-1:0]     found_ff, found_in;
   logic [CNT_W-1:0]       stale_ff, stale_in;
   logic                   pend_valid_ff, pend_valid_in;
   rsp_item_type           pend_ff, pend_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type           rsp_ff, rsp_in;

   logic                   accept;
   logic                   mod_start;
   logic                   mod_done;
   logic [IDX_W-1:0]       mod_index;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   slot_entry_type         wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   slot_entry_type         rd_data;
   logic [TIME_W-1:0]      threshold;
   logic                   age_over;
   logic                   live;
   logic                   due;

   rtt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rtt_index_mod #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_ff.seq_num),
      .done     (mod_done),
      .index    (mod_index)
   );

   rtt_slot_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rtt_age_unit u_age (
      .time_now  (time_ff),
      .stamp     (rd_data.stamp),
      .threshold (threshold),
      .over      (age_over)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign threshold  = (req_ff.req_type == REQ_LOSS) ? cfg.ack_timeout : cfg.retry_timeout;
   assign live       = eval_valid_ff && valid_ff[eval_idx_ff] && !rd_data.acked;
   assign due        = live && age_over && (rd_data.retries < cfg.max_retries)
                       && (found_ff < MAX_OUT_CNT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (req_ff.req_type inside {REQ_RECORD, REQ_ACK}) begin
               state_in = ST_MOD;
            end else if (req_ff.req_type inside {REQ_RETRANSMIT, REQ_LOSS}) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = (req_ff.req_type == REQ_ACK) ? ST_ACK_CHECK : ST_IDLE;
            end
         end
         ST_ACK_CHECK: state_in = ST_IDLE;
         ST_SCAN: begin
            if (issue_ff == DEPTH_CNT && eval_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in        = accept ? req_data : req_ff;
      valid_in      = valid_ff;
      time_in       = time_ff;
      acked_in      = acked_ff;
      resent_in     = resent_ff;
      lost_in       = lost_ff;
      slot_idx_in   = slot_idx_ff;
      issue_in      = issue_ff;
      eval_valid_in = 1'b0;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      stale_in      = stale_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      mod_start     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = mod_index;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = mod_index;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      case (state_ff)
         ST_DECODE: begin
            mod_start     = (req_ff.req_type inside {REQ_RECORD, REQ_ACK});
            issue_in      = '0;
            found_in      = '0;
            stale_in      = '0;
            pend_valid_in = 1'b0;
            if (req_ff.req_type == REQ_TICK) begin
               time_in = time_ff + 1'b1;
            end
            if (!(req_ff.req_type inside {REQ_RECORD, REQ_ACK, REQ_RETRANSMIT, REQ_LOSS}))
            begin
               rsp_strobe_in = 1'b1;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               slot_idx_in = mod_index;
               if (req_ff.req_type == REQ_ACK) begin
                  rd_en = 1'b1;
               end else begin
                  wr_en               = 1'b1;
                  wr_data.seq         = req_ff.seq_num;
                  wr_data.acked       = 1'b0;
                  wr_data.stamp       = time_ff;
                  wr_data.retries     = '0;
                  valid_in[mod_index] = 1'b1;
                  rsp_strobe_in       = 1'b1;
               end
            end
         end
         ST_ACK_CHECK: begin
            rsp_strobe_in = 1'b1;
            wr_addr       = slot_idx_ff;
            if (valid_ff[slot_idx_ff] && rd_data.seq == req_ff.seq_num) begin
               wr_en         = 1'b1;
               wr_data.acked = 1'b1;
               acked_in      = sat_add(acked_ff, TOTAL_W'(1));
            end
         end
         ST_SCAN: begin
            if (issue_ff != DEPTH_CNT) begin
               rd_en         = 1'b1;
               rd_addr       = issue_ff[IDX_W-1:0];
               issue_in      = issue_ff + 1'b1;
               eval_valid_in = 1'b1;
               eval_idx_in   = issue_ff[IDX_W-1:0];
            end
            if (req_ff.req_type == REQ_LOSS) begin
               if (live && age_over) begin
                  stale_in = stale_ff + 1'b1;
               end
            end else if (due) begin
               wr_en           = 1'b1;
               wr_addr         = eval_idx_ff;
               wr_data.retries = rd_data.retries + 1'b1;
               wr_data.stamp   = time_ff;
               resent_in       = sat_add(resent_ff, TOTAL_W'(1));
               found_in        = found_ff + 1'b1;
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
               end
               pend_valid_in        = 1'b1;
               pend_in.kind         = KIND_RETRANSMIT;
               pend_in.out_seq      = rd_data.seq;
               pend_in.retries_used = rd_data.retries + 1'b1;
               pend_in.acked_total  = acked_ff;
               pend_in.resent_total = resent_in;
               pend_in.lost_total   = lost_ff;
               pend_in.last         = 1'b0;
            end
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            if (req_ff.req_type == REQ_LOSS) begin
               lost_in = sat_add(lost_ff, TOTAL_W'(stale_ff));
            end
         end
         default: ;
      endcase

      if (state_ff == ST_SCAN) begin
         rsp_in = pend_ff;
      end else if (state_ff == ST_FINISH && req_ff.req_type == REQ_RETRANSMIT
                   && pend_valid_ff) begin
         rsp_in      = pend_ff;
         rsp_in.last = 1'b1;
      end else begin
         rsp_in.kind         = KIND_DONE;
         rsp_in.out_seq      = '0;
         rsp_in.retries_used = '0;
         rsp_in.acked_total  = acked_in;
         rsp_in.resent_total = resent_in;
         rsp_in.lost_total   = lost_in;
         rsp_in.last         = 1'b1;
         if (state_ff == ST_ACK_CHECK && acked_in == acked_ff
             && !(valid_ff[slot_idx_ff] && rd_data.seq == req_ff.seq_num)) begin
            rsp_in.kind = KIND_ACK_MISS;
         end
         if (state_ff == ST_FINISH) begin
            rsp_in.kind = (req_ff.req_type == REQ_LOSS) ? KIND_LOSS_DONE : KIND_NOTHING_DUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         time_ff       <= '0;
         acked_ff      <= '0;
         resent_ff     <= '0;
         lost_ff       <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         issue_ff      <= '0;
         found_ff      <= '0;
         stale_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         time_ff       <= time_in;
         acked_ff      <= acked_in;
         resent_ff     <= resent_in;
         lost_ff       <= lost_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         issue_ff      <= issue_in;
         found_ff      <= found_in;
         stale_ff      <= stale_in;
      end
      req_ff      <= req_in;
      slot_idx_ff <= slot_idx_in;
      eval_idx_ff <= eval_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

endmodule
